@@ hdl/utf8v_pkg.sv @@
package utf8v_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_buffer;
	} byte_item_t;

	typedef struct packed {
		logic [31:0] seq_bytes;
		logic [20:0] code_point;
		logic [2:0]  consumed;
		logic        is_valid;
		logic        last_of_run;
	} res_item_t;

	// what one registered byte does to the result queue and the held sequence
	typedef struct packed {
		logic [1:0]  n_res;
		res_item_t   r0;
		res_item_t   r1;
		logic [31:0] held_bytes;
		logic [2:0]  held_count;
	} step_out_t;

	localparam logic [31:0] REPL_BYTES = 32'h00BD_BFEF;
	localparam logic [20:0] REPL_CP    = 21'h00_FFFD;
	localparam logic [20:0] CP_MAX     = 21'h10_FFFF;
	localparam logic [20:0] SURR_LO    = 21'h00_D800;
	localparam logic [20:0] SURR_HI    = 21'h00_DFFF;
	localparam logic [20:0] NONCHAR_LO = 21'h00_FFFE;
	localparam logic [1:0]  LEAD_MARK  = 2'b11;
	localparam logic [1:0]  CONT_MARK  = 2'b10;

endpackage

@@ hdl/utf8v_step.sv @@
module utf8v_step (
	input  utf8v_pkg::byte_item_t item,
	input  logic [31:0]           held_bytes,
	input  logic [2:0]            held_count,
	output utf8v_pkg::step_out_t  res
);
	import utf8v_pkg::*;

	function automatic logic [20:0] decode_seq(input logic [31:0] v, input logic [2:0] n);
		case (n)
			3'd2: return {10'b0, v[4:0], v[13:8]};
			3'd3: return {5'b0, v[3:0], v[13:8], v[21:16]};
			3'd4: return {v[2:0], v[13:8], v[21:16], v[29:24]};
			default: return {13'b0, v[7:0]};
		endcase
	endfunction

	function automatic logic [31:0] encode_cp(input logic [20:0] cp);
		if (cp <= 21'h00_007F)
			return {11'b0, cp};
		if (cp <= 21'h00_07FF)
			return {16'b0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
		if (cp <= 21'h00_FFFF) begin
			if (cp >= NONCHAR_LO || (cp >= SURR_LO && cp <= SURR_HI))
				return REPL_BYTES;
			return {8'b0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
		end
		if (cp <= CP_MAX)
			return {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
		return REPL_BYTES;
	endfunction

	// decode, re-encode and compare
	function automatic res_item_t make_seq(input logic [31:0] v, input logic [2:0] n,
		input logic last);
		logic [20:0] cp;
		logic        ok;
		res_item_t   r;
		cp = decode_seq(v, n);
		ok = (encode_cp(cp) == v);
		r.seq_bytes   = ok ? v : REPL_BYTES;
		r.code_point  = ok ? cp : REPL_CP;
		r.consumed    = n;
		r.is_valid    = ok;
		r.last_of_run = last;
		return r;
	endfunction

	// a lone byte round-trips only when it is ascii
	function automatic res_item_t make_single(input logic [7:0] b, input logic last);
		res_item_t r;
		r.seq_bytes   = b[7] ? REPL_BYTES : {24'b0, b};
		r.code_point  = b[7] ? REPL_CP : {13'b0, b};
		r.consumed    = 3'd1;
		r.is_valid    = !b[7];
		r.last_of_run = last;
		return r;
	endfunction

	always_comb begin
		logic [7:0]  b;
		logic        eob;
		logic        is_open;
		logic        absorb;
		logic        done;
		logic        fresh_open;
		logic        second;
		logic [31:0] appended;
		logic [31:0] cand_v;
		logic [2:0]  cand_n;
		logic        seq_last;
		res_item_t   seq_r;

		b          = item.in_byte;
		eob        = item.end_of_buffer;
		is_open    = (held_count != 3'd0);
		absorb     = is_open && (b[7:6] == CONT_MARK);
		done       = (held_count == 3'd3) || eob;
		fresh_open = (b[7:6] == LEAD_MARK) && !eob;
		second     = !fresh_open;
		appended   = held_bytes | ({24'b0, b} << {held_count[1:0], 3'b000});

		cand_v   = absorb ? appended : held_bytes;
		cand_n   = absorb ? (held_count + 3'd1) : held_count;
		seq_last = absorb ? 1'b1 : !second;
		seq_r    = make_seq(cand_v, cand_n, seq_last);

		res.r1 = make_single(b, 1'b1);
		if (absorb) begin
			res.r0         = seq_r;
			res.n_res      = done ? 2'd1 : 2'd0;
			res.held_bytes = done ? 32'd0 : appended;
			res.held_count = done ? 3'd0 : cand_n;
		end else begin
			res.r0         = is_open ? seq_r : make_single(b, 1'b1);
			res.n_res      = {1'b0, is_open} + {1'b0, second};
			res.held_bytes = fresh_open ? {24'b0, b} : 32'd0;
			res.held_count = fresh_open ? 3'd1 : 3'd0;
		end
	end

endmodule

@@ hdl/utf8v_outq.sv @@
module utf8v_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           push_n,
	input  utf8v_pkg::res_item_t push0,
	input  utf8v_pkg::res_item_t push1,
	output logic [1:0]           free,
	output logic                 res_valid,
	input  logic                 res_stall,
	output utf8v_pkg::res_item_t res_item
);
	import utf8v_pkg::*;

	logic [1:0] cnt_q;
	res_item_t  q_q [3];
	res_item_t  sh [3];
	logic       pop;
	logic [1:0] base;

	assign res_valid = (cnt_q != 2'd0);
	assign res_item  = q_q[0];
	assign pop       = res_valid && !res_stall;
	assign base      = cnt_q - {1'b0, pop};
	assign free      = 2'd3 - base;

	// shift down on pop
	always_comb begin
		sh[0] = pop ? q_q[1] : q_q[0];
		sh[1] = pop ? q_q[2] : q_q[1];
		sh[2] = q_q[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= base + push_n;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (push_n != 2'd0 && 2'(i) == base) begin
				q_q[i] <= push0;
			end else if (push_n == 2'd2 && 2'(i) == base + 2'd1) begin
				q_q[i] <= push1;
			end else begin
				q_q[i] <= sh[i];
			end
		end
	end

endmodule

@@ hdl/utf8_stream_validating_decoder_top.sv @@
// channel  | valid      | stall      | payload
// bytes in | byte_valid | byte_stall | byte_item (in_byte, end_of_buffer)
// results  | res_valid  | res_stall  | res_item  (seq_bytes .. last_of_run)
//
// one byte accepted per cycle while byte_stall is low; its results reach the queue
// through the input register; a byte that closes a held sequence and stands alone gives
// two results, which leave one per cycle through the three-entry result queue while
// res_stall is low; reset clears the held sequence, the input register and the queue
// byte_stall rises only while the registered byte cannot fit its results in the queue

module utf8_stream_validating_decoder_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  utf8v_pkg::byte_item_t byte_item,
	output logic                  res_valid,
	input  logic                  res_stall,
	output utf8v_pkg::res_item_t  res_item
);
	import utf8v_pkg::*;

	logic        valid_s1;
	byte_item_t  item_s1;
	logic [31:0] held_bytes_q;
	logic [2:0]  held_count_q;
	step_out_t   step;
	logic [1:0]  free;
	logic        advance;
	logic [1:0]  push_n;

	utf8v_step u_step (
		.item       (item_s1),
		.held_bytes (held_bytes_q),
		.held_count (held_count_q),
		.res        (step)
	);

	assign advance    = valid_s1 && (step.n_res <= free);
	assign byte_stall = valid_s1 && !advance;
	assign push_n     = advance ? step.n_res : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			held_bytes_q <= 32'd0;
			held_count_q <= 3'd0;
		end else begin
			if (byte_valid && !byte_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				held_bytes_q <= step.held_bytes;
				held_count_q <= step.held_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_item;
		end
	end

	utf8v_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push0     (step.r0),
		.push1     (step.r1),
		.free      (free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

endmodule

@@ hdl/utf8v_checker.sv @@
module utf8v_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 byte_valid,
	input logic                 byte_stall,
	input logic                 res_valid,
	input logic                 res_stall,
	input utf8v_pkg::res_item_t res_item
);
	import utf8v_pkg::*;

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res_item)))
		else $error("result changed while stalled");

	// the first of a pair is followed at once by the lone terminating byte
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && !res_item.last_of_run) |=>
		(res_valid && res_item.consumed == 3'd1 && res_item.last_of_run))
		else $error("pair of results broken");

	// queue is empty during reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !res_valid)
		else $error("result shown during reset");

	// input stall only follows an accepted item
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_stall && !$past(byte_stall)) |-> $past(byte_valid))
		else $error("stall without a held item");

endmodule

bind utf8_stream_validating_decoder_top utf8v_checker u_utf8v_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_stall (byte_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res_item   (res_item)
);
